// ----- hdl/ldq_pkg.sv -----
// Package for the linear array deque: sizes, operation and status codes,
// payload structs and the command/status structs between controller and datapath.
// No dependencies.
package ldq_pkg;

  localparam int DEPTH = 256;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CAP_W = 9;
  localparam int VAL_W = 32;

  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_REAR  = 3'd1;
  localparam logic [2:0] OP_REM_FRONT = 3'd2;
  localparam logic [2:0] OP_REM_REAR  = 3'd3;
  localparam logic [2:0] OP_SEARCH    = 3'd4;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_REFUSED   = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  typedef struct packed {
    logic [2:0]              operation;
    logic signed [VAL_W-1:0] value;
  } ldq_req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] removed_value;
    logic                    found;
  } ldq_rsp_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic finish_remove;
    logic scan_step;
    logic publish;
  } ldq_cmd_t;

  typedef struct packed {
    logic need_read;
    logic need_scan;
    logic scan_end;
    logic rsp_free;
  } ldq_stat_t;

endpackage

// ----- hdl/ldq_ctrl.sv -----
// Controller state machine of the linear array deque.
// Sequences one transaction at a time through the datapath; uses ldq_pkg.
module ldq_ctrl import ldq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  ldq_stat_t st,
  output ldq_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_READ = 5'b00100,
    S_SCAN = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    req_stall = 1'b1;
    case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (st.need_read) begin
          state_next = S_READ;
        end else if (st.need_scan) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_READ: begin
        cmd.finish_remove = 1'b1;
        state_next = S_DONE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_end) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (st.rsp_free) begin
          cmd.publish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/ldq_datapath.sv -----
// Datapath of the linear array deque: slot memory, indices, capacity register,
// staged result and output register. Driven by ldq_ctrl; uses ldq_pkg.
module ldq_datapath import ldq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  input  ldq_req_t         req_data,
  input  ldq_cmd_t         cmd,
  output ldq_stat_t        st,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output ldq_rsp_t         rsp_data
);

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rdata;
  logic [2:0]              op_reg;
  logic signed [VAL_W-1:0] val_reg;
  logic [IDX_W-1:0]        front, front_next;
  logic [IDX_W-1:0]        rear, rear_next;
  logic [IDX_W-1:0]        ptr, ptr_next;
  logic                    empty, empty_next;
  logic [CAP_W-1:0]        cap;
  ldq_rsp_t                res, res_next;

  logic [CAP_W-1:0] eff_cap;
  logic             rear_full;
  logic             match;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;

  always_comb begin
    if (cap == '0) begin
      eff_cap = CAP_W'(1);
    end else if (cap > CAP_W'(DEPTH)) begin
      eff_cap = CAP_W'(DEPTH);
    end else begin
      eff_cap = cap;
    end
  end

  assign rear_full = (CAP_W'(rear) + CAP_W'(1)) >= eff_cap;
  assign match = (rdata == val_reg);

  assign st.need_read = ((op_reg == OP_REM_FRONT) || (op_reg == OP_REM_REAR)) && !empty;
  assign st.need_scan = (op_reg == OP_SEARCH) && !empty;
  assign st.scan_end  = match || (ptr == rear);
  assign st.rsp_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    front_next = front;
    rear_next  = rear;
    empty_next = empty;
    ptr_next   = ptr;
    res_next   = res;
    mem_we     = 1'b0;
    mem_waddr  = front;
    mem_raddr  = ptr + IDX_W'(1);
    if (cmd.exec) begin
      res_next = '0;
      case (op_reg)
        OP_INS_FRONT: begin
          if (empty || (front == '0)) begin
            res_next.status = ST_REFUSED;
          end else begin
            front_next = front - IDX_W'(1);
            mem_we     = 1'b1;
            mem_waddr  = front - IDX_W'(1);
          end
        end
        OP_INS_REAR: begin
          if (empty) begin
            front_next = '0;
            rear_next  = '0;
            empty_next = 1'b0;
            mem_we     = 1'b1;
            mem_waddr  = '0;
          end else if (rear_full) begin
            res_next.status = ST_REFUSED;
          end else begin
            rear_next = rear + IDX_W'(1);
            mem_we    = 1'b1;
            mem_waddr = rear + IDX_W'(1);
          end
        end
        OP_REM_FRONT: begin
          if (empty) begin
            res_next.status = ST_UNDERFLOW;
          end
          mem_raddr = front;
        end
        OP_REM_REAR: begin
          if (empty) begin
            res_next.status = ST_UNDERFLOW;
          end
          mem_raddr = rear;
        end
        OP_SEARCH: begin
          mem_raddr = front;
          ptr_next  = front;
        end
        default: begin
        end
      endcase
    end
    if (cmd.finish_remove) begin
      res_next.removed_value = rdata;
      if (front == rear) begin
        empty_next = 1'b1;
        front_next = '0;
        rear_next  = '0;
      end else if (op_reg == OP_REM_FRONT) begin
        front_next = front + IDX_W'(1);
      end else begin
        rear_next = rear - IDX_W'(1);
      end
    end
    if (cmd.scan_step) begin
      if (st.scan_end) begin
        res_next.found = match;
      end else begin
        ptr_next = ptr + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= val_reg;
    end
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_reg  <= req_data.operation;
      val_reg <= req_data.value;
    end
    ptr <= ptr_next;
    res <= res_next;
    if (cmd.publish) begin
      rsp_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      rear      <= '0;
      empty     <= 1'b1;
      cap       <= CAP_RESET;
      rsp_valid <= 1'b0;
    end else begin
      front <= front_next;
      rear  <= rear_next;
      empty <= empty_next;
      if (cfg_we) begin
        cap <= cfg_wdata;
      end
      if (cmd.publish) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/linear_array_deque.sv -----
// Top level of the linear array deque; instantiates ldq_ctrl and ldq_datapath.
// Uses ldq_pkg.
//
// The block takes one transaction at a time and returns exactly one result for
// each. A search reads from 1 to 256 slots, from the front until a match or the
// rear is reached; the slot memory has one read port and the scan reads one slot
// per cycle. A finished result sits in an output register, so a new request is
// taken while the previous result waits. No clearing pass is run after reset;
// the queue is usable as soon as reset is released.
module linear_array_deque import ldq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  input  logic             req_valid,
  output logic             req_stall,
  input  ldq_req_t         req_data,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output ldq_rsp_t         rsp_data
);

  ldq_cmd_t  cmd;
  ldq_stat_t st;

  ldq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .st        (st),
    .cmd       (cmd)
  );

  ldq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_data  (req_data),
    .cmd       (cmd),
    .st        (st),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  // A new transaction is never taken while one is still being processed.
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted while busy");

  // A result is only loaded when the output register is free.
  assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!rsp_valid || !rsp_stall))
    else $error("result overwrote a pending result");

  // After a result is published the block is ready for the next request.
  assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> !req_stall)
    else $error("not ready after publishing a result");

  // A published result is presented in the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> rsp_valid)
    else $error("published result not presented");

endmodule
